// ===== src/et_pkg.sv =====
// ----------------------------------------------------------------------------
// et_pkg
// Shared types and constants for the Euler totient block: data width,
// controller states, and the command and status bundles.
// ----------------------------------------------------------------------------
package et_pkg;

  localparam int unsigned VALUE_BITS    = 16;
  localparam int unsigned DIV_CNT_BITS  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  typedef logic [VALUE_BITS-1:0]   value_t;
  typedef logic [2*VALUE_BITS-1:0] wide_t;
  typedef logic [DIV_CNT_BITS-1:0] div_cnt_t;

  localparam value_t VALUE_ONE = value_t'(1);
  localparam value_t FIRST_CAND = value_t'(2);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_FINAL = 6'b010000,
    ST_DONE  = 6'b100000
  } et_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // take a new value, reset the search
    logic div_start;   // launch n / cand
    logic take_quot;   // n <= quotient
    logic next_cand;   // cand <= cand + 1, next factor is a new prime
    logic mul_factor;  // result <= result * (first ? cand-1 : cand)
    logic mul_final;   // result <= result * (n > 1 ? n-1 : 1)
    logic out_load;    // copy result into the output register
  } et_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic keep_going;  // n > 1 and cand * cand <= n
  } et_status_t;

endpackage

// ===== src/et_div.sv =====
// ----------------------------------------------------------------------------
// et_div
// Restoring divider: one quotient bit per cycle, VALUE_BITS quotient steps
// per division, done pulse in the cycle after the last step.
// ----------------------------------------------------------------------------
module et_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  et_pkg::value_t dividend_i,
  input  et_pkg::value_t divisor_i,
  output logic           done_o,
  output et_pkg::value_t quot_o,
  output et_pkg::value_t rem_o
);
  import et_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  div_cnt_t            cnt_q, cnt_d;
  value_t              quot_q, quot_d;
  value_t              rem_q, rem_d;
  value_t              dvsr_q, dvsr_d;
  logic [VALUE_BITS:0] rem_shift;
  logic [VALUE_BITS:0] rem_trial;

  assign rem_shift = {rem_q, quot_q[VALUE_BITS-1]};
  assign rem_trial = rem_shift - {1'b0, dvsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
    end else if (busy_q) begin
      // Shift in the next dividend bit, subtract when it fits
      if (!rem_trial[VALUE_BITS]) begin
        rem_d  = rem_trial[VALUE_BITS-1:0];
        quot_d = {quot_q[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_d  = rem_shift[VALUE_BITS-1:0];
        quot_d = {quot_q[VALUE_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + div_cnt_t'(1);
      if (cnt_q == div_cnt_t'(VALUE_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/et_dpath.sv =====
// ----------------------------------------------------------------------------
// et_dpath
// Datapath: cofactor, candidate divisor and running product registers, the
// shared multiplier, the square check, the divider and the output register.
// ----------------------------------------------------------------------------
module et_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  et_pkg::et_cmd_t   cmd_i,
  input  et_pkg::value_t    value_i,
  output et_pkg::et_status_t status_o,
  output et_pkg::value_t    totient_value_o
);
  import et_pkg::*;

  value_t n_q, n_d;
  value_t cand_q, cand_d;
  value_t result_q, result_d;
  logic   first_q, first_d;
  value_t out_q, out_d;

  value_t div_quot;
  value_t div_rem;
  logic   div_done;

  value_t factor;
  value_t mul_op;
  wide_t  prod;
  wide_t  cand_sq;
  logic   n_gt1;

  et_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (n_q),
    .divisor_i  (cand_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign n_gt1   = (n_q > VALUE_ONE);
  assign cand_sq = wide_t'(cand_q) * wide_t'(cand_q);

  // First hit of a prime contributes p-1, each further hit contributes p
  assign factor = first_q ? (cand_q - VALUE_ONE) : cand_q;
  assign mul_op = cmd_i.mul_final ? (n_gt1 ? (n_q - VALUE_ONE) : VALUE_ONE) : factor;
  assign prod   = wide_t'(result_q) * wide_t'(mul_op);

  always_comb begin
    n_d      = n_q;
    cand_d   = cand_q;
    result_d = result_q;
    first_d  = first_q;
    out_d    = out_q;
    if (cmd_i.load) begin
      n_d      = value_i;
      cand_d   = FIRST_CAND;
      result_d = VALUE_ONE;
      first_d  = 1'b1;
    end
    if (cmd_i.take_quot) begin
      n_d = div_quot;
    end
    if (cmd_i.next_cand) begin
      cand_d  = cand_q + VALUE_ONE;
      first_d = 1'b1;
    end
    if (cmd_i.mul_factor || cmd_i.mul_final) begin
      result_d = prod[VALUE_BITS-1:0];
    end
    if (cmd_i.mul_factor) begin
      first_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_d = result_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    cand_q   <= cand_d;
    result_q <= result_d;
    first_q  <= first_d;
    out_q    <= out_d;
  end

  assign status_o.div_done   = div_done;
  assign status_o.rem_zero   = (div_rem == '0);
  assign status_o.keep_going = n_gt1 && (cand_sq <= wide_t'(n_q));
  assign totient_value_o     = out_q;

endmodule

// ===== src/et_ctrl.sv =====
// ----------------------------------------------------------------------------
// et_ctrl
// Controller: sequences the trial division search and owns both handshakes.
// ----------------------------------------------------------------------------
module et_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  et_pkg::et_status_t status_i,
  output et_pkg::et_cmd_t    cmd_o
);
  import et_pkg::*;

  et_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;
  et_cmd_t   cmd;
  logic      out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.keep_going) begin
          cmd.div_start = 1'b1;
          state_d       = ST_DIV;
        end else begin
          state_d = ST_FINAL;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            cmd.take_quot = 1'b1;
            state_d       = ST_MUL;
          end else begin
            cmd.next_cand = 1'b1;
            state_d       = ST_CHECK;
          end
        end
      end
      ST_MUL: begin
        // Fold in the factor and try the same candidate again
        cmd.mul_factor = 1'b1;
        cmd.div_start  = 1'b1;
        state_d        = ST_DIV;
      end
      ST_FINAL: begin
        cmd.mul_final = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ===== src/euler_totient_top.sv =====
// ----------------------------------------------------------------------------
// euler_totient_top
// Euler's totient of one unsigned 16-bit value per beat, by trial division.
// ----------------------------------------------------------------------------
// One input beat gives one output beat holding phi(value); 0 and 1 both give
// 1. The block works on one value at a time: in_stall_o is low only while it
// waits for work. The time per value is set by the bit-serial divider. Each
// trial division holds the engine for its 16 quotient steps and the done
// pulse, and one more state, ST_CHECK or ST_MUL, either checks the next
// candidate or folds in the factor just found. The search tries candidates
// from 2 up to about the square root of the remaining cofactor, and runs one
// more division for each prime factor, counted with multiplicity, found below
// that bound. The last candidate check, the final fold and the hand-off to
// the output register end the run; the engine then returns to idle and takes
// the next value. A prime near 65535 is the worst case (254 candidates);
// small or smooth values finish far sooner. The finished result sits in an
// output register, so a new value is taken while the previous result waits
// for out_stall_i to drop; if that result still waits when the next one is
// done, the engine holds until the output register frees up.
// ----------------------------------------------------------------------------
module euler_totient_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  et_pkg::value_t value_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output et_pkg::value_t totient_value_o
);
  import et_pkg::*;

  et_cmd_t    cmd;
  et_status_t status;

  // Sequencer: accept, search, fold factors, hand off the result
  et_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Registers, divider, multiplier and output register
  et_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (value_i),
    .status_o        (status),
    .totient_value_o (totient_value_o)
  );

endmodule

// ===== src/et_checker.sv =====
// ----------------------------------------------------------------------------
// et_checker
// Port-level checks for the Euler totient block, bound to the top level.
// ----------------------------------------------------------------------------
module et_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input et_pkg::value_t totient_value_o
);
  import et_pkg::*;

  // Hold an offered output beat while stalled
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(totient_value_o))
    else $error("output payload changed while stalled");

  // An accepted beat occupies the engine for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // A new result only appears after the engine was busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

  // phi is at least 1 for every input, so a fresh result is never zero
  a_result_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (totient_value_o != '0))
    else $error("zero totient produced");

endmodule

bind euler_totient_top et_checker u_et_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .totient_value_o (totient_value_o)
);

// ===== tb/euler_totient_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_totient_top_test
// Self-checking bench for the trial-division totient block.
// ----------------------------------------------------------------------------
// A driver pulls values from a queue and presents them on the input channel
// with random gaps. A monitor predicts phi(value) for every accepted beat and
// checks each output beat against the oldest prediction. The output side
// stalls at random. A short directed list comes first, then random values
// biased toward the slow and tricky cases: values near the top, prime squares,
// products of two primes and smooth numbers.
// ----------------------------------------------------------------------------
module euler_totient_top_test;
  import et_pkg::*;

  // Queued input beat: the value, the idle cycles in front of it, and
  // whether the sender holds it back until all results are in.
  typedef struct {
    value_t      value;
    int unsigned gap;
    bit          drain;
  } value_beat_t;

  localparam int unsigned N_DIRECTED = 20;
  localparam int unsigned N_RANDOM   = 80;
  localparam int unsigned TAIL_CYCLES = 200;

  logic   clk_i;
  logic   rst_ni          = 1'b0;
  logic   in_valid_i      = 1'b0;
  logic   in_stall_o;
  value_t value_i         = '0;
  logic   out_valid_o;
  logic   out_stall_i     = 1'b0;
  value_t totient_value_o;

  value_beat_t value_q [$];
  value_t      totient_q [$];

  logic        in_beat = 1'b0;
  int unsigned stall_left = 0;
  int unsigned fail_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned drain_cnt = 0;
  value_t      want_totient;

  value_t directed_vals [N_DIRECTED] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd49, 16'd97,
    16'd30030, 16'd32768, 16'd65535, 16'd65534, 16'd65521, 16'd63001,
    16'd64009, 16'd65025, 16'd43690, 16'd21845, 16'd65280, 16'd64507
  };

  euler_totient_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .totient_value_o (totient_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Predict phi(v): strip each prime power p^e found by rising trial
  // divisors and fold in p^(e-1)*(p-1). Stop once cand^2 passes the
  // cofactor; whatever is left above one is a single prime.
  function automatic value_t totient_of(value_t v);
    int unsigned rest;
    int unsigned cand;
    int unsigned acc;
    int unsigned part;
    rest = v;
    acc  = 1;
    cand = 2;
    while (rest > 1 && cand * cand <= rest) begin
      if (rest % cand == 0) begin
        rest = rest / cand;
        part = cand - 1;
        while (rest % cand == 0) begin
          rest = rest / cand;
          part = part * cand;
        end
        acc = acc * part;
      end
      cand++;
    end
    if (rest > 1) acc = acc * (rest - 1);
    return value_t'(acc);
  endfunction

  // Smallest prime at or above n.
  function automatic int unsigned prime_from(int unsigned n);
    int unsigned p;
    int unsigned d;
    bit          comp;
    p = (n < 2) ? 2 : n;
    forever begin
      comp = 1'b0;
      for (d = 2; d * d <= p; d++) begin
        if (p % d == 0) comp = 1'b1;
      end
      if (!comp) return p;
      p++;
    end
  endfunction

  // Idle cycles in front of a beat: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  // Input driver: advance on the falling edge. Hold the current beat until
  // the monitor saw it taken, then burn the head's gap, then present it.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_beat) begin
      if (value_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (value_q[0].gap != 0) begin
        value_q[0].gap--;
        in_valid_i <= 1'b0;
      end else if (value_q[0].drain && totient_q.size() != 0) begin
        // hold off until every pending result has come back
        in_valid_i <= 1'b0;
      end else begin
        if (value_q[0].drain) drain_cnt++;
        in_valid_i <= 1'b1;
        value_i    <= value_q[0].value;
        void'(value_q.pop_front());
      end
    end
  end

  // Output stall pattern: segments of free running, short stalls, long
  // stalls, and long stall-free stretches.
  always @(negedge clk_i) begin
    int unsigned r;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        out_stall_i <= 1'b0;
        stall_left  <= $urandom_range(1, 20);
      end else if (r < 8) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(1, 3);
      end else if (r == 8) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(20, 150);
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= $urandom_range(200, 600);
      end
    end
  end

  // Monitor: sample both channels on the rising edge. Predict on every
  // accepted input beat; check every accepted output beat in order.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_beat <= 1'b0;
    end else begin
      in_beat <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) totient_q = {totient_q, totient_of(value_i)};
      if (out_valid_o && !out_stall_i) begin
        if (totient_q.size() == 0) begin
          $error("unexpected output beat: totient_value=%0d", totient_value_o);
          fail_cnt++;
        end else begin
          want_totient = totient_q.pop_front();
          checked_cnt++;
          if (totient_value_o !== want_totient) begin
            $error("totient_value: expected %0d, got %0d",
                   want_totient, totient_value_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    value_beat_t b;
    int unsigned i;
    int unsigned p;
    int unsigned q;
    int unsigned v;
    int unsigned f;

    // Directed: zero, one, tiny values, exact prime squares where the
    // search ends with cand^2 == n, the largest prime, prime times prime
    // with a prime cofactor left over, powers of two and bit patterns.
    // The first few go back to back; one waits for a full drain.
    for (i = 0; i < N_DIRECTED; i++) begin
      b.value = directed_vals[i];
      b.gap   = (i < 6) ? 0 : pick_gap();
      b.drain = (i == 10);
      value_q = {value_q, b};
    end

    // Random: a mix of full-range values, small ones, smooth numbers,
    // prime squares and products, and values right below the top.
    for (i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 5))
        0: v = $urandom_range(0, 300);
        1, 2: v = $urandom_range(0, 65535);
        3: begin
          v = 1;
          repeat ($urandom_range(1, 14)) begin
            case ($urandom_range(0, 5))
              0: f = 2;
              1: f = 3;
              2: f = 5;
              3: f = 7;
              4: f = 11;
              default: f = 13;
            endcase
            if (v * f <= 65535) v = v * f;
          end
        end
        4: begin
          p = prime_from($urandom_range(2, 250));
          q = ($urandom_range(0, 1) == 0) ? p : prime_from($urandom_range(2, 65535 / p));
          v = p * q;
          if (v > 65535) v = p;
        end
        default: v = 65535 - $urandom_range(0, 200);
      endcase
      b.value = value_t'(v);
      // every third block of sixteen runs without input gaps
      b.gap   = ((i / 16) % 3 == 1) ? 0 : pick_gap();
      b.drain = (i % 25 == 24);
      value_q = {value_q, b};
    end

    // Reset: hold, then release on a falling edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all beats sent and every prediction matched.
    while (value_q.size() != 0 || in_valid_i || totient_q.size() != 0)
      @(posedge clk_i);
    // Watch a little longer for stray output beats.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d totient results over %0d directed and %0d random values,",
             checked_cnt, N_DIRECTED, N_RANDOM);
    $display("with %0d full drains and random stalls on both channels.", drain_cnt);
    if (fail_cnt == 0) begin
      $display("[euler_totient_top] OK");
    end else begin
      $display("[euler_totient_top] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #12000000;
    $display("Timeout with %0d results still pending.", totient_q.size());
    $display("[euler_totient_top] ERROR");
    $finish;
  end

endmodule
